/* src/tterm_pkg.sv */
// ----------------------------------------------------------------------------
// tterm_pkg
// Shared types and constants for the text terminal cursor engine: command
// codes, character codes, controller states and the command/result beats.
// ----------------------------------------------------------------------------
package tterm_pkg;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_SETPOS = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_CLEAR
    } state_t;

    localparam logic [7:0]  CHAR_TAB   = 8'd9;
    localparam logic [7:0]  CHAR_NL    = 8'd10;
    localparam logic [7:0]  CHAR_CR    = 8'd13;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [15:0] BLANK_CELL = 16'h0720;
    localparam logic [3:0]  FG_RESET   = 4'd7;
    localparam logic [3:0]  BG_RESET   = 4'd0;

    localparam logic REG_FG_COLOR = 1'b0;
    localparam logic REG_BG_COLOR = 1'b1;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] char_code;
        logic [7:0] row_sel;
        logic [7:0] col_sel;
    } tterm_in_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [15:0] cell_entry;
        logic        scrolled;
    } tterm_out_t;

endpackage

/* src/tterm_screen_ram.sv */
// ----------------------------------------------------------------------------
// tterm_screen_ram
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tterm_screen_ram #(
    parameter int DEPTH = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [15:0]       wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [15:0]       rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/text_terminal_cursor_engine_unit.sv */
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine_unit
// Put, set position, read: result strobe in the cycle after accept; next beat
// may start in that cycle. Scroll: one cell copy per cycle through the single
// read port, then a fill of the bottom row, then the strobe. Clear: a sweep of
// every cell, then the strobe. Reset runs the same clearing pass (busy high,
// no strobe); results cannot stall.
// ----------------------------------------------------------------------------
module text_terminal_cursor_engine_unit
    import tterm_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  tterm_in_t  command,
    output logic       done,
    output tterm_out_t result,
    input  logic       wr_en,
    input  logic       wr_index,
    input  logic [3:0] wr_data
);

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);

    localparam logic [CNT_W-1:0]  CELLS_C   = CNT_W'(CELL_COUNT);
    localparam logic [CNT_W-1:0]  LAST_C    = CNT_W'(CELL_COUNT - 1);
    localparam logic [CNT_W-1:0]  COLS_C    = CNT_W'(SCREEN_COLUMNS);
    localparam logic [CNT_W-1:0]  BOTTOM_C  = CNT_W'(CELL_COUNT - SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLUMNS);
    localparam logic [7:0]        COLS_8    = 8'(SCREEN_COLUMNS);
    localparam logic [7:0]        ROWS_8    = 8'(SCREEN_ROWS);
    localparam logic [5:0]        ROWS_6    = 6'(SCREEN_ROWS);
    localparam logic [4:0]        LAST_ROW  = 5'(SCREEN_ROWS - 1);

    state_t            state_reg, state_next;
    logic [4:0]        cur_row_reg, cur_row_next;
    logic [6:0]        cur_col_reg, cur_col_next;
    logic [3:0]        fg_reg, bg_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pipe_valid_reg, pipe_valid_next;
    logic [ADDR_W-1:0] pipe_addr_reg, pipe_addr_next;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic              scrolled_reg, scrolled_next;
    logic              quiet_reg, quiet_next;

    logic              accept;
    logic              new_line;
    logic              need_scroll;
    logic [4:0]        put_row;
    logic [6:0]        put_col;
    logic              put_write;
    logic [7:0]        tab_sum;
    logic [7:0]        col_inc;
    logic [5:0]        row_inc;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] sel_addr;
    logic [CNT_W-1:0]  cnt_back;
    logic              read_hit;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign cur_addr = ADDR_W'(cur_row_reg) * COLS_A + ADDR_W'(cur_col_reg);
    assign sel_addr = ADDR_W'(command.row_sel) * COLS_A + ADDR_W'(command.col_sel);
    assign cnt_back = cnt_reg - COLS_C;
    assign read_hit = (command.row_sel < ROWS_8) && (command.col_sel < COLS_8);
    assign col_inc  = {1'b0, cur_col_reg} + 8'd1;
    assign row_inc  = {1'b0, cur_row_reg} + 6'd1;
    // round up to the next tab stop: add 8, drop the low three bits
    assign tab_sum  = {1'b0, cur_col_reg} + 8'd8;

    // put-character decode, shared by next state and datapath
    always_comb
    begin
        new_line  = 1'b0;
        put_write = 1'b0;
        put_row   = cur_row_reg;
        put_col   = cur_col_reg;
        case (command.char_code)
            CHAR_NL:
            begin
                new_line = 1'b1;
            end
            CHAR_CR:
            begin
                put_col = '0;
            end
            CHAR_TAB:
            begin
                if ({tab_sum[7:3], 3'b000} >= COLS_8)
                begin
                    new_line = 1'b1;
                end
                else
                begin
                    put_col = tab_sum[6:0] & 7'h78;
                end
            end
            default:
            begin
                put_write = 1'b1;
                if (col_inc >= COLS_8)
                begin
                    new_line = 1'b1;
                end
                else
                begin
                    put_col = col_inc[6:0];
                end
            end
        endcase
        need_scroll = new_line && (row_inc >= ROWS_6);
        if (new_line)
        begin
            put_col = '0;
            put_row = need_scroll ? LAST_ROW : row_inc[4:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && command.cmd == CMD_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else if (accept && command.cmd == CMD_PUT && need_scroll)
                begin
                    state_next = ST_SCROLL;
                end
            end
            ST_SCROLL:
            begin
                if (cnt_reg == CELLS_C)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL, ST_CLEAR:
            begin
                if (cnt_reg == LAST_C)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        cnt_next        = cnt_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = pipe_addr_reg;
        done_next       = 1'b0;
        hit_next        = 1'b0;
        scrolled_next   = scrolled_reg;
        quiet_next      = quiet_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_addr;
        mem_wdata       = {bg_reg, fg_reg, command.char_code};
        mem_re          = 1'b0;
        mem_raddr       = sel_addr;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scrolled_next = 1'b0;
                    done_next     = 1'b1;
                    unique case (command.cmd)
                        CMD_PUT:
                        begin
                            mem_we       = put_write;
                            cur_row_next = put_row;
                            cur_col_next = put_col;
                            if (need_scroll)
                            begin
                                done_next     = 1'b0;
                                scrolled_next = 1'b1;
                                cnt_next      = COLS_C;
                            end
                        end
                        CMD_SETPOS:
                        begin
                            if (command.row_sel < ROWS_8)
                            begin
                                cur_row_next = command.row_sel[4:0];
                            end
                            if (command.col_sel < COLS_8)
                            begin
                                cur_col_next = command.col_sel[6:0];
                            end
                        end
                        CMD_CLEAR:
                        begin
                            done_next    = 1'b0;
                            cur_row_next = '0;
                            cur_col_next = '0;
                            cnt_next     = '0;
                        end
                        CMD_READ:
                        begin
                            mem_re   = read_hit;
                            hit_next = read_hit;
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // copy row below into the write slot in the cycle after its read
                mem_we    = pipe_valid_reg;
                mem_waddr = pipe_addr_reg;
                mem_wdata = mem_rdata;
                if (cnt_reg == CELLS_C)
                begin
                    cnt_next = BOTTOM_C;
                end
                else
                begin
                    mem_re          = 1'b1;
                    mem_raddr       = cnt_reg[ADDR_W-1:0];
                    pipe_valid_next = 1'b1;
                    pipe_addr_next  = cnt_back[ADDR_W-1:0];
                    cnt_next        = cnt_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = {bg_reg, fg_reg, CHAR_SPACE};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_C)
                begin
                    done_next = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = BLANK_CELL;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_C)
                begin
                    // the pass after reset reports nothing
                    done_next  = !quiet_reg;
                    quiet_next = 1'b0;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            cnt_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            scrolled_reg   <= 1'b0;
            quiet_reg      <= 1'b1;
            fg_reg         <= FG_RESET;
            bg_reg         <= BG_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            cnt_reg        <= cnt_next;
            pipe_valid_reg <= pipe_valid_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            scrolled_reg   <= scrolled_next;
            quiet_reg      <= quiet_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_FG_COLOR: fg_reg <= wr_data;
                    REG_BG_COLOR: bg_reg <= wr_data;
                    default:      fg_reg <= fg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= pipe_addr_next;
    end

    tterm_screen_ram #(
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign done              = done_reg;
    assign result.cursor_row = cur_row_reg;
    assign result.cursor_col = cur_col_reg;
    assign result.cell_entry = hit_reg ? mem_rdata : 16'd0;
    assign result.scrolled   = scrolled_reg;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a sweep is still running");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg < LAST_ROW + 5'd1 || SCREEN_ROWS == 32)
        && ({1'b0, cur_col_reg} < COLS_8))
        else $error("cursor outside the screen");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.scrolled) |-> (result.cursor_row == LAST_ROW
        && result.cursor_col == 7'd0))
        else $error("scroll did not leave cursor at start of last row");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command.cmd == CMD_CLEAR) |=> busy)
        else $error("clear accepted without a sweep");

    a_cell_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.cell_entry != 16'd0)
        |-> $past(start && !busy && command.cmd == CMD_READ))
        else $error("cell data on a result that is not a read");
`endif

endmodule
